/* rtl/rsa_pkg.sv */
`default_nettype none

package rsa_pkg;

  localparam int WORD_BITS   = 16;
  localparam int STACK_DEPTH = 4;
  localparam int OUT_LEVELS  = 4;
  localparam int CNT_BITS    = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  localparam logic [2:0] REQ_OPERATE = 3'd0;
  localparam logic [2:0] REQ_PUSH    = 3'd1;
  localparam logic [2:0] REQ_SWAP    = 3'd2;
  localparam logic [2:0] REQ_INC     = 3'd3;
  localparam logic [2:0] REQ_DEC     = 3'd4;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_LAND = 4'd4;
  localparam logic [3:0] OP_LOR  = 4'd5;
  localparam logic [3:0] OP_LNOT = 4'd6;
  localparam logic [3:0] OP_AND  = 4'd7;
  localparam logic [3:0] OP_OR   = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_XOR  = 4'd10;
  localparam logic [3:0] OP_SHL  = 4'd11;
  localparam logic [3:0] OP_SHR  = 4'd12;

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  typedef enum logic [3:0] {
    K_ADD, K_SUB, K_MUL, K_DIV, K_LAND, K_LOR, K_LNOT, K_AND,
    K_OR, K_NOT, K_XOR, K_SHL, K_SHR, K_INC, K_DEC, K_PASS
  } alu_kind_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_POP, WB_TOP, WB_PUSH, WB_SWAP
  } wb_t;

  typedef enum logic {
    ST_IDLE, ST_RUN
  } state_t;

  typedef struct packed {
    logic      start;
    alu_kind_t kind;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic dz;
  } alu_sts_t;

  function automatic word_t digit_step(input logic [1:0] base, input logic [3:0] pos);
    logic [3:0] p;
    word_t      v;
    p = pos;
    v = word_t'(1);
    case (base)
      BASE_BIN: v = word_t'(1) << p;
      BASE_OCT: begin
        if (p > 4'd5) p = 4'd5;
        v = word_t'(1) << (3 * p);
      end
      BASE_DEC: begin
        if (p > 4'd4) p = 4'd4;
        case (p)
          4'd0:    v = word_t'(1);
          4'd1:    v = word_t'(10);
          4'd2:    v = word_t'(100);
          4'd3:    v = word_t'(1000);
          default: v = word_t'(10000);
        endcase
      end
      default: begin
        if (p > 4'd3) p = 4'd3;
        v = word_t'(1) << (4 * p);
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/rpn_stack_alu_unit.sv */
// Channel   Handshake         Word
// in        start / busy      in_req_type, in_alu_op, in_digit_base, in_digit_position
// out       out_valid strobe  out_top_value .. out_fourth_value, out_div_by_zero
//
// The result strobe follows the accepting edge once the shared ALU has run its
// bit-serial steps, one per word bit, and the stack has been written.
// Busy drops in the strobe cycle, so the next command is taken at the edge
// that ends it; no new command is taken while one is still running.
// Synchronous reset clears the stack to zero; results cannot be stalled.
`default_nettype none

module rpn_stack_alu_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [2:0]          in_req_type,
  input  wire  [3:0]          in_alu_op,
  input  wire  [1:0]          in_digit_base,
  input  wire  [3:0]          in_digit_position,
  output logic                out_valid,
  output rsa_pkg::word_t      out_top_value,
  output rsa_pkg::word_t      out_second_value,
  output rsa_pkg::word_t      out_third_value,
  output rsa_pkg::word_t      out_fourth_value,
  output logic                out_div_by_zero
);
  import rsa_pkg::*;

  state_t    state_r, state_nxt;
  wb_t       wb_r, wb_dec;
  alu_kind_t kind_dec;
  alu_ctl_t  ctl;
  alu_sts_t  sts;
  word_t     opa, opb, result;
  word_t     stack_r [STACK_DEPTH];
  word_t     lvl [OUT_LEVELS];
  logic      out_valid_r, dz_out_r;
  logic      accept;

  assign accept = start && !busy;

  always_comb begin
    kind_dec = K_PASS;
    wb_dec   = WB_NONE;
    unique case (in_req_type)
      REQ_OPERATE: begin
        unique case (in_alu_op)
          OP_ADD:  kind_dec = K_ADD;
          OP_SUB:  kind_dec = K_SUB;
          OP_MUL:  kind_dec = K_MUL;
          OP_DIV:  kind_dec = K_DIV;
          OP_LAND: kind_dec = K_LAND;
          OP_LOR:  kind_dec = K_LOR;
          OP_LNOT: kind_dec = K_LNOT;
          OP_AND:  kind_dec = K_AND;
          OP_OR:   kind_dec = K_OR;
          OP_NOT:  kind_dec = K_NOT;
          OP_XOR:  kind_dec = K_XOR;
          OP_SHL:  kind_dec = K_SHL;
          OP_SHR:  kind_dec = K_SHR;
          default: kind_dec = K_PASS;
        endcase
        unique case (in_alu_op) inside
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LAND, OP_LOR, OP_AND, OP_OR, OP_XOR:
            wb_dec = WB_POP;
          OP_LNOT, OP_NOT, OP_SHL, OP_SHR:
            wb_dec = WB_TOP;
          default:
            wb_dec = WB_NONE;
        endcase
      end
      REQ_PUSH: wb_dec = WB_PUSH;
      REQ_SWAP: wb_dec = WB_SWAP;
      REQ_INC: begin
        kind_dec = K_INC;
        wb_dec   = WB_TOP;
      end
      REQ_DEC: begin
        kind_dec = K_DEC;
        wb_dec   = WB_TOP;
      end
      default: wb_dec = WB_NONE;
    endcase
  end

  always_comb begin
    opa = stack_r[1];
    opb = stack_r[0];
    case (kind_dec) inside
      K_INC, K_DEC: begin
        opa = stack_r[0];
        opb = digit_step(in_digit_base, in_digit_position);
      end
      K_SHL:   opb = {stack_r[0][WORD_BITS-2:0], 1'b0};
      K_SHR:   opb = {1'b0, stack_r[0][WORD_BITS-1:1]};
      default: opb = stack_r[0];
    endcase
    ctl.start = accept;
    ctl.kind  = kind_dec;
  end

  rsa_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .opa    (opa),
    .opb    (opb),
    .result (result),
    .sts    (sts)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (sts.done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_RUN:  busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dz_out_r    <= 1'b0;
      wb_r        <= WB_NONE;
      for (int i = 0; i < STACK_DEPTH; i++) stack_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= sts.done;
      if (accept) wb_r <= wb_dec;
      if (sts.done) begin
        dz_out_r <= sts.dz;
        case (wb_r)
          WB_POP: begin
            stack_r[0] <= result;
            for (int i = 1; i < STACK_DEPTH - 1; i++) stack_r[i] <= stack_r[i+1];
            stack_r[STACK_DEPTH-1] <= '0;
          end
          WB_TOP: stack_r[0] <= result;
          WB_PUSH: begin
            for (int i = 1; i < STACK_DEPTH; i++) stack_r[i] <= stack_r[i-1];
            stack_r[0] <= '0;
          end
          WB_SWAP: begin
            stack_r[0] <= stack_r[1];
            stack_r[1] <= stack_r[0];
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < OUT_LEVELS; i++) lvl[i] = '0;
    for (int i = 0; i < STACK_DEPTH && i < OUT_LEVELS; i++) lvl[i] = stack_r[i];
  end

  assign out_valid        = out_valid_r;
  assign out_div_by_zero  = dz_out_r;
  assign out_top_value    = lvl[0];
  assign out_second_value = lvl[1];
  assign out_third_value  = lvl[2];
  assign out_fourth_value = lvl[3];

endmodule

`default_nettype wire

/* rtl/rsa_serial_alu.sv */
`default_nettype none

module rsa_serial_alu (
  input  wire                clk,
  input  wire                rst_n,
  input  rsa_pkg::alu_ctl_t  ctl,
  input  rsa_pkg::word_t     opa,
  input  rsa_pkg::word_t     opb,
  output rsa_pkg::word_t     result,
  output rsa_pkg::alu_sts_t  sts
);
  import rsa_pkg::*;

  alu_kind_t kind_r;
  logic      run_r, run_nxt;
  logic      done_r, done_nxt;
  cnt_t      cnt_r, cnt_nxt;
  word_t     a_r, a_nxt;
  word_t     b_r, b_nxt;
  word_t     acc_r, acc_nxt;
  word_t     res_r, res_nxt;
  logic      carry_r, carry_nxt;
  logic      nz_a_r, nz_a_nxt;
  logic      nz_b_r, nz_b_nxt;
  logic      dz_r;

  logic                abit, bbit, bsum, sbit, rbit;
  logic [WORD_BITS:0]  trial, diff;

  always_comb begin
    abit  = a_r[0];
    bbit  = b_r[0];
    bsum  = (kind_r == K_SUB || kind_r == K_DEC) ? ~bbit : bbit;
    sbit  = abit ^ bsum ^ carry_r;
    trial = {acc_r, a_r[WORD_BITS-1]};
    diff  = trial - {1'b0, b_r};
    case (kind_r) inside
      K_ADD, K_SUB, K_INC, K_DEC: rbit = sbit;
      K_AND:                      rbit = abit & bbit;
      K_OR:                       rbit = abit | bbit;
      K_XOR:                      rbit = abit ^ bbit;
      K_NOT:                      rbit = ~bbit;
      K_SHL, K_SHR:               rbit = bbit;
      default:                    rbit = 1'b0;
    endcase
  end

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    carry_nxt = carry_r;
    nz_a_nxt  = nz_a_r;
    nz_b_nxt  = nz_b_r;
    if (ctl.start) begin
      run_nxt   = 1'b1;
      cnt_nxt   = '0;
      a_nxt     = opa;
      b_nxt     = opb;
      acc_nxt   = '0;
      res_nxt   = '0;
      carry_nxt = (ctl.kind == K_SUB || ctl.kind == K_DEC);
      nz_a_nxt  = 1'b0;
      nz_b_nxt  = 1'b0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + cnt_t'(1);
      if (cnt_r == cnt_t'(WORD_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
      case (kind_r)
        K_MUL: begin
          if (bbit) acc_nxt = acc_r + a_r;
          a_nxt = {a_r[WORD_BITS-2:0], 1'b0};
          b_nxt = {1'b0, b_r[WORD_BITS-1:1]};
        end
        K_DIV: begin
          if (!diff[WORD_BITS]) begin
            acc_nxt = diff[WORD_BITS-1:0];
            a_nxt   = {a_r[WORD_BITS-2:0], 1'b1};
          end else begin
            acc_nxt = trial[WORD_BITS-1:0];
            a_nxt   = {a_r[WORD_BITS-2:0], 1'b0};
          end
        end
        default: begin
          a_nxt     = {1'b0, a_r[WORD_BITS-1:1]};
          b_nxt     = {1'b0, b_r[WORD_BITS-1:1]};
          res_nxt   = {rbit, res_r[WORD_BITS-1:1]};
          carry_nxt = (abit & bsum) | (abit & carry_r) | (bsum & carry_r);
          nz_a_nxt  = nz_a_r | abit;
          nz_b_nxt  = nz_b_r | bbit;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    carry_r <= carry_nxt;
    nz_a_r  <= nz_a_nxt;
    nz_b_r  <= nz_b_nxt;
    if (ctl.start) begin
      kind_r <= ctl.kind;
      dz_r   <= (ctl.kind == K_DIV) && (opb == '0);
    end
  end

  always_comb begin
    case (kind_r)
      K_MUL:   result = acc_r;
      K_DIV:   result = a_r;
      K_INC:   result = carry_r ? '1 : res_r;
      K_DEC:   result = carry_r ? res_r : '0;
      K_LAND:  result = word_t'(nz_a_r & nz_b_r);
      K_LOR:   result = word_t'(nz_a_r | nz_b_r);
      K_LNOT:  result = word_t'(!nz_b_r);
      K_PASS:  result = '0;
      default: result = res_r;
    endcase
    sts.done = done_r;
    sts.dz   = dz_r;
  end

endmodule

`default_nettype wire
